// ===== src/assert_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ccalloc_pkg.sv =====
// Types and constants shared by the contiguous chunk allocator.
`timescale 1ns / 1ps

package ccalloc_pkg;

  // Field widths of the request and result transfers
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned CFG_W   = 7;

  // Byte delta of one run: up to 127 chunks of 4096 bytes
  localparam int unsigned DELTA_W = 19;

  // No run or usable count ever reaches past this many chunks
  localparam int unsigned MAP_CAP = 128;

  localparam logic [BYTES_W-1:0] BYTES_MAX = 13'h1FFF;
  localparam logic [CFG_W-1:0]   POOL_RST  = 7'd64;

  // Request opcodes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a request transfer
    logic search;  // build the fit vector and byte delta
    logic commit;  // update the map and load the result register
  } ctl_t;

endpackage

// ===== src/ccalloc_ctrl.sv =====
// Controller state machine of the contiguous chunk allocator.
`timescale 1ns / 1ps

module ccalloc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ccalloc_pkg::ctl_t  ctl_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WORK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       commit_fire;
  logic       take;

  // Commit only when the result register is free or being drained
  always_comb begin
    commit_fire = (state_q == ST_COMMIT) && !(out_valid_q && out_stall_i);
    take        = in_valid_i && ((state_q == ST_IDLE) || commit_fire);
  end

  // Advance the request sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_WORK;
      end
      ST_WORK: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_fire) state_d = take ? ST_WORK : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result valid until its transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = !((state_q == ST_IDLE) || commit_fire);
  assign out_valid_o  = out_valid_q;
  assign ctl_o.load   = take;
  assign ctl_o.search = (state_q == ST_WORK);
  assign ctl_o.commit = commit_fire;

endmodule

// ===== src/ccalloc_dp.sv =====
// Datapath of the contiguous chunk allocator: chunk map, run lengths, search, counter.
`timescale 1ns / 1ps

module ccalloc_dp #(
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned CHUNK_BYTES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ccalloc_pkg::ctl_t                   ctl_i,
  input  logic                                cfg_we_i,
  input  logic [ccalloc_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                                cmd_i,
  input  logic [ccalloc_pkg::SIZE_W-1:0]      size_bytes_i,
  input  logic [ccalloc_pkg::IDX_W-1:0]       chunk_index_i,
  output logic                                ok_o,
  output logic [ccalloc_pkg::IDX_W-1:0]       first_chunk_o,
  output logic [ccalloc_pkg::RUN_W-1:0]       run_chunks_o,
  output logic [ccalloc_pkg::BYTES_W-1:0]     used_bytes_o
);

  // Chunks that can ever be reached: usable count and run length stay below 128
  localparam int unsigned DEPTH = (MAX_CHUNKS < ccalloc_pkg::MAP_CAP) ?
                                  MAX_CHUNKS : ccalloc_pkg::MAP_CAP;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned PADW  = DEPTH + ccalloc_pkg::MAP_CAP;
  localparam int unsigned LVL   = ccalloc_pkg::RUN_W;
  localparam int unsigned SUM_W = ccalloc_pkg::DELTA_W + 1;

  // Round-up division by the chunk size as a reciprocal multiply, exact below 2^14
  localparam int unsigned X_W    = ccalloc_pkg::SIZE_W + 1;
  localparam int unsigned SHIFT  = 27;
  localparam int unsigned RCP_W  = SHIFT + 1;
  localparam int unsigned PROD_W = X_W + RCP_W;
  localparam int unsigned NEED_W = PROD_W - SHIFT;
  localparam longint unsigned RCP = ((64'd1 << SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam logic [RCP_W-1:0]  RCP_V = RCP[RCP_W-1:0];
  localparam logic [X_W-1:0]    CB_M1 = X_W'(CHUNK_BYTES - 1);
  localparam logic [ccalloc_pkg::DELTA_W-1:0] CB_V = ccalloc_pkg::DELTA_W'(CHUNK_BYTES);
  localparam logic [7:0]        DEPTH_V = 8'(DEPTH);

  // Architectural state
  logic [ccalloc_pkg::CFG_W-1:0]   pool_q;
  logic [DEPTH-1:0]                used_q, used_d;
  logic [DEPTH-1:0]                start_q, start_d;
  logic [ccalloc_pkg::BYTES_W-1:0] bytes_q, bytes_d;
  logic [ccalloc_pkg::RUN_W-1:0]   len_mem [DEPTH];

  // Request registers
  logic                            cmd_q;
  logic [ccalloc_pkg::RUN_W-1:0]   need_q;
  logic                            too_big_q;
  logic [IW-1:0]                   idx_q;
  logic                            in_range_q;
  logic [ccalloc_pkg::RUN_W-1:0]   rd_q;
  logic [DEPTH-1:0]                fit_q;
  logic [ccalloc_pkg::DELTA_W-1:0] delta_q;

  // Result registers
  logic                            ok_q;
  logic [ccalloc_pkg::IDX_W-1:0]   first_q;
  logic [ccalloc_pkg::RUN_W-1:0]   run_q;
  logic [ccalloc_pkg::BYTES_W-1:0] used_out_q;

  // Request decode
  logic [X_W-1:0]                  x_w;
  logic [PROD_W-1:0]               prod_w;
  logic [NEED_W-1:0]               need_full;
  logic [7:0]                      idx_ext;
  logic [IW-1:0]                   rd_addr;

  // Search
  logic [PADW-1:0]                 lvl [LVL];
  logic [PADW-1:0]                 win [LVL+1];
  logic [ccalloc_pkg::RUN_W-1:0]   len_sel;

  // Commit
  logic [DEPTH-1:0]                fit_low;
  logic [IW-1:0]                   s_enc;
  logic                            alloc_ok, free_ok, ok_w;
  logic [IW-1:0]                   base;
  logic [7:0]                      base8;
  logic [ccalloc_pkg::RUN_W-1:0]   len_w;
  logic [DEPTH-1:0]                mask;
  logic [SUM_W-1:0]                sum_w;
  logic                            wr_en;

  // Work out the chunk count and the free index of an incoming request
  always_comb begin
    x_w       = X_W'(size_bytes_i) + CB_M1;
    prod_w    = PROD_W'(x_w) * PROD_W'(RCP_V);
    need_full = prod_w[PROD_W-1:SHIFT];
    idx_ext   = 8'(chunk_index_i);
    rd_addr   = idx_ext[IW-1:0];
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= cmd_i;
      too_big_q  <= (need_full > NEED_W'(ccalloc_pkg::RUN_W'('1)));
      need_q     <= (need_full == '0) ? ccalloc_pkg::RUN_W'(1) :
                    need_full[ccalloc_pkg::RUN_W-1:0];
      idx_q      <= rd_addr;
      in_range_q <= (idx_ext < DEPTH_V);
    end
  end

  // Build the fit vector: bit s set when need chunks from s are all free and usable
  always_comb begin
    lvl[0] = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lvl[0][i] = !used_q[i] && (8'(i) < 8'(pool_q));
    end
    for (int k = 0; k < LVL - 1; k++) begin
      lvl[k+1] = lvl[k] & (lvl[k] >> (1 << k));
    end
    win[0] = '1;
    for (int k = 0; k < LVL; k++) begin
      win[k+1] = need_q[k] ? (lvl[k] & (win[k] >> (1 << k))) : win[k];
    end
    len_sel = (cmd_q == ccalloc_pkg::CMD_FREE) ? rd_q : need_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.search) begin
      fit_q   <= win[LVL][DEPTH-1:0];
      delta_q <= ccalloc_pkg::DELTA_W'(len_sel) * CB_V;
    end
  end

  // Pick the first fit, form the run mask and the new byte count
  always_comb begin
    fit_low = fit_q & (~fit_q + DEPTH'(1));
    s_enc   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (fit_low[i]) s_enc = s_enc | IW'(i);
    end
    alloc_ok = (cmd_q == ccalloc_pkg::CMD_ALLOC) && !too_big_q && (|fit_q);
    free_ok  = (cmd_q == ccalloc_pkg::CMD_FREE) && in_range_q && start_q[idx_q];
    ok_w     = alloc_ok || free_ok;
    base     = (cmd_q == ccalloc_pkg::CMD_FREE) ? idx_q : s_enc;
    base8    = 8'(base);
    len_w    = (cmd_q == ccalloc_pkg::CMD_FREE) ? rd_q : need_q;
    for (int i = 0; i < DEPTH; i++) begin
      mask[i] = (8'(i) >= base8) && ((8'(i) - base8) < 8'(len_w));
    end
    sum_w   = SUM_W'(bytes_q) + SUM_W'(delta_q);
    used_d  = used_q;
    start_d = start_q;
    bytes_d = bytes_q;
    if (alloc_ok) begin
      used_d        = used_q | mask;
      start_d[base] = 1'b1;
      bytes_d       = (sum_w > SUM_W'(ccalloc_pkg::BYTES_MAX)) ?
                      ccalloc_pkg::BYTES_MAX : sum_w[ccalloc_pkg::BYTES_W-1:0];
    end else if (free_ok) begin
      used_d        = used_q & ~mask;
      start_d[base] = 1'b0;
      bytes_d       = (delta_q > ccalloc_pkg::DELTA_W'(bytes_q)) ? '0 :
                      (bytes_q - delta_q[ccalloc_pkg::BYTES_W-1:0]);
    end
    wr_en = ctl_i.commit && alloc_ok;
  end

  // Update the map, run starts, counter and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= ccalloc_pkg::POOL_RST;
      used_q  <= '0;
      start_q <= '0;
      bytes_q <= '0;
    end else begin
      if (cfg_we_i) pool_q <= cfg_wdata_i;
      if (ctl_i.commit) begin
        used_q  <= used_d;
        start_q <= start_d;
        bytes_q <= bytes_d;
      end
    end
  end

  // Run length store: written at a run start, read when a request is captured
  always_ff @(posedge clk_i) begin
    if (wr_en) len_mem[s_enc] <= need_q;
    if (ctl_i.load) begin
      rd_q <= (wr_en && (s_enc == rd_addr)) ? need_q : len_mem[rd_addr];
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      ok_q       <= ok_w;
      first_q    <= ok_w ? base8[ccalloc_pkg::IDX_W-1:0] : '0;
      run_q      <= ok_w ? len_w : '0;
      used_out_q <= bytes_d;
    end
  end

  assign ok_o          = ok_q;
  assign first_chunk_o = first_q;
  assign run_chunks_o  = run_q;
  assign used_bytes_o  = used_out_q;

endmodule

// ===== src/contiguous_chunk_allocator.sv =====
// A request is captured, then the fit search is registered, then the commit loads the result register.
// A new request can be taken while the previous one commits, but not while it is in the fit search.
// A stalled result holds the commit stage, which then holds the request side.
// Reset: all chunks free, no run starts, byte counter zero, pool_chunks at 64.
// Run length entries are defined once written at a run start.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contiguous_chunk_allocator #(
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned CHUNK_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccalloc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [ccalloc_pkg::SIZE_W-1:0]  size_bytes_i,
  input  logic [ccalloc_pkg::IDX_W-1:0]   chunk_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic [ccalloc_pkg::IDX_W-1:0]   first_chunk_o,
  output logic [ccalloc_pkg::RUN_W-1:0]   run_chunks_o,
  output logic [ccalloc_pkg::BYTES_W-1:0] used_bytes_o
);

  ccalloc_pkg::ctl_t ctl;

  // Sequence requests
  ccalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // Search and update the chunk map
  ccalloc_dp #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .size_bytes_i  (size_bytes_i),
    .chunk_index_i (chunk_index_i),
    .ok_o          (ok_o),
    .first_chunk_o (first_chunk_o),
    .run_chunks_o  (run_chunks_o),
    .used_bytes_o  (used_bytes_o)
  );

  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while search pending")
  `ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, ctl.commit, out_valid_o, "commit did not present a result")
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, ctl.commit, !(out_valid_o && out_stall_i), "result overwritten while stalled")
  `ASSERT_IMPL(a_fail_clean, clk_i, rst_ni, out_valid_o && !ok_o, (run_chunks_o == 0) && (first_chunk_o == 0), "failed result carries a run")

endmodule

// ===== tb/alloc_checker.sv =====
// Scoreboard for the contiguous chunk allocator: predicts each result and compares it.
`timescale 1ns / 1ps

module alloc_checker #(
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned CHUNK_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccalloc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            cmd_i,
  input  logic [ccalloc_pkg::SIZE_W-1:0]  size_bytes_i,
  input  logic [ccalloc_pkg::IDX_W-1:0]   chunk_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            ok_i,
  input  logic [ccalloc_pkg::IDX_W-1:0]   first_chunk_i,
  input  logic [ccalloc_pkg::RUN_W-1:0]   run_chunks_i,
  input  logic [ccalloc_pkg::BYTES_W-1:0] used_bytes_i,
  output int                              errors_o,
  output int                              pending_o
);

  localparam int unsigned RUN_LIMIT  = (1 << ccalloc_pkg::RUN_W) - 1;
  localparam int unsigned BYTE_CEIL  = 32'(ccalloc_pkg::BYTES_MAX);

  typedef struct packed {
    logic                            ok;
    logic [ccalloc_pkg::IDX_W-1:0]   first;
    logic [ccalloc_pkg::RUN_W-1:0]   run;
    logic [ccalloc_pkg::BYTES_W-1:0] used;
  } alloc_result_t;

  // Shadow copy of the allocator state
  logic                          chunk_used [MAX_CHUNKS];
  int unsigned                   run_len [MAX_CHUNKS];
  int unsigned                   byte_count;
  logic [ccalloc_pkg::CFG_W-1:0] pool_cfg;

  // Results predicted for accepted requests, oldest first
  alloc_result_t expected_results[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // First-fit search for a run of adjacent free chunks below the usable count
  function automatic alloc_result_t allocate_run(input int unsigned size);
    int unsigned   need;
    int unsigned   limit;
    int unsigned   start;
    int unsigned   blocked;
    int unsigned   add;
    bit            found;
    alloc_result_t res;
    res   = '0;
    need  = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
    if (need == 0) need = 1;
    limit = (pool_cfg < MAX_CHUNKS) ? pool_cfg : MAX_CHUNKS;
    start = 0;
    found = 1'b0;
    if (need <= RUN_LIMIT) begin
      while (!found && start + need <= limit) begin
        blocked = limit;
        for (int unsigned k = 0; k < need; k++) begin
          if (blocked == limit && chunk_used[start + k]) blocked = start + k;
        end
        // restart just past the first used chunk
        if (blocked == limit) found = 1'b1;
        else start = blocked + 1;
      end
    end
    if (found) begin
      for (int unsigned k = 0; k < need; k++) chunk_used[start + k] = 1'b1;
      run_len[start] = need;
      add = need * CHUNK_BYTES;
      byte_count = (add > BYTE_CEIL - byte_count) ? BYTE_CEIL : byte_count + add;
      res.ok    = 1'b1;
      res.first = start[ccalloc_pkg::IDX_W-1:0];
      res.run   = need[ccalloc_pkg::RUN_W-1:0];
    end
    res.used = byte_count[ccalloc_pkg::BYTES_W-1:0];
    return res;
  endfunction

  // Release a whole run named by its first chunk; the pool size plays no part
  function automatic alloc_result_t release_run(input int unsigned idx);
    int unsigned   len;
    int unsigned   sub;
    alloc_result_t res;
    res = '0;
    if (idx < MAX_CHUNKS && chunk_used[idx] && run_len[idx] != 0) begin
      len = run_len[idx];
      for (int unsigned k = 0; k < len && idx + k < MAX_CHUNKS; k++) begin
        chunk_used[idx + k] = 1'b0;
        run_len[idx + k]    = 0;
      end
      sub = len * CHUNK_BYTES;
      byte_count = (sub > byte_count) ? 0 : byte_count - sub;
      res.ok    = 1'b1;
      res.first = idx[ccalloc_pkg::IDX_W-1:0];
      res.run   = len[ccalloc_pkg::RUN_W-1:0];
    end
    res.used = byte_count[ccalloc_pkg::BYTES_W-1:0];
    return res;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    alloc_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        chunk_used[i] = 1'b0;
        run_len[i]    = 0;
      end
      byte_count = 0;
      pool_cfg   = ccalloc_pkg::POOL_RST;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) pool_cfg = cfg_wdata_i;
      // compare the result transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: ok %b first %0d",
                                    ok_i, first_chunk_i));
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 16'(ok_i), 16'(want.ok));
          check_field("first_chunk", 16'(first_chunk_i), 16'(want.first));
          check_field("run_chunks", 16'(run_chunks_i), 16'(want.run));
          check_field("used_bytes", 16'(used_bytes_i), 16'(want.used));
        end
      end
      // predict the request transfer
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == ccalloc_pkg::CMD_ALLOC) begin
          expected_results.push_back(allocate_run(32'(size_bytes_i)));
        end else begin
          expected_results.push_back(release_run(32'(chunk_index_i)));
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the contiguous chunk allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CHUNKS         = 64;
  localparam int unsigned CHUNK_BYTES_TB = 64;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned LONG_HOLD      = 60;

  logic                            clk_i     = 1'b0;
  logic                            rst_ni    = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [ccalloc_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  logic                            req_cmd   = ccalloc_pkg::CMD_ALLOC;
  logic [ccalloc_pkg::SIZE_W-1:0]  req_size  = '0;
  logic [ccalloc_pkg::IDX_W-1:0]   req_index = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  logic                            rsp_ok;
  logic [ccalloc_pkg::IDX_W-1:0]   rsp_first;
  logic [ccalloc_pkg::RUN_W-1:0]   rsp_run;
  logic [ccalloc_pkg::BYTES_W-1:0] rsp_used;

  int          fail_count;
  int          results_due;
  int          tx_idle_pct = 21;
  int          rx_idle_pct = 59;
  logic        hold_req    = 1'b0;
  logic        hold_ack    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;

  // Run starts seen in results, used to aim free requests
  logic [CHUNKS-1:0] live_runs = '0;
  logic              inflight_cmds[$];

  contiguous_chunk_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .cmd_i         (req_cmd),
    .size_bytes_i  (req_size),
    .chunk_index_i (req_index),
    .out_valid_o   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .ok_o          (rsp_ok),
    .first_chunk_o (rsp_first),
    .run_chunks_o  (rsp_run),
    .used_bytes_o  (rsp_used)
  );

  alloc_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (req_valid),
    .in_stall_i    (req_stall),
    .cmd_i         (req_cmd),
    .size_bytes_i  (req_size),
    .chunk_index_i (req_index),
    .out_valid_i   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .ok_i          (rsp_ok),
    .first_chunk_i (rsp_first),
    .run_chunks_i  (rsp_run),
    .used_bytes_i  (rsp_used),
    .errors_o      (fail_count),
    .pending_o     (results_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the response side at random, or hold it off for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Track which chunks start a live run
  always @(posedge clk_i) begin
    if (rsp_valid && !rsp_stall && inflight_cmds.size() != 0) begin
      if (rsp_ok) live_runs[rsp_first] <= (inflight_cmds[0] == ccalloc_pkg::CMD_ALLOC);
      void'(inflight_cmds.pop_front());
    end
    if (req_valid && !req_stall) inflight_cmds.push_back(req_cmd);
  end

  function automatic logic [ccalloc_pkg::IDX_W-1:0] pick_run_start();
    int unsigned base;
    base = $urandom_range(CHUNKS - 1);
    for (int unsigned k = 0; k < CHUNKS; k++) begin
      if (live_runs[(base + k) % CHUNKS]) return ccalloc_pkg::IDX_W'((base + k) % CHUNKS);
    end
    return ccalloc_pkg::IDX_W'(base);
  endfunction

  function automatic logic [ccalloc_pkg::IDX_W-1:0] pick_index();
    return ccalloc_pkg::IDX_W'($urandom_range(CHUNKS - 1));
  endfunction

  function automatic logic [ccalloc_pkg::SIZE_W-1:0] pick_any_size();
    return ccalloc_pkg::SIZE_W'($urandom_range((1 << ccalloc_pkg::SIZE_W) - 1));
  endfunction

  // Mostly small runs, a few up to the whole pool and beyond
  function automatic logic [ccalloc_pkg::SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return ccalloc_pkg::SIZE_W'($urandom_range(256));
    if (roll < 85) return ccalloc_pkg::SIZE_W'($urandom_range(1024));
    if (roll < 95) return ccalloc_pkg::SIZE_W'($urandom_range(4096));
    return pick_any_size();
  endfunction

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_request(input logic cmd, input logic [ccalloc_pkg::SIZE_W-1:0] size,
                              input logic [ccalloc_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_cmd   <= cmd;
    req_size  <= size;
    req_index <= idx;
    do @(posedge clk_i); while (req_stall);
  endtask

  // Drop valid and wait for every predicted result
  task automatic settle_results();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  task automatic set_pool_chunks(input logic [ccalloc_pkg::CFG_W-1:0] value);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int count, input int hold_at, input int pause_at);
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req <= ~hold_req;
      if (n == pause_at) settle_results();
      roll = $urandom_range(99);
      if (roll < 50) begin
        send_request(ccalloc_pkg::CMD_ALLOC, pick_size(), pick_index());
      end else if (roll < 90) begin
        send_request(ccalloc_pkg::CMD_FREE, pick_any_size(), pick_run_start());
      end else begin
        send_request(ccalloc_pkg::CMD_FREE, pick_any_size(), pick_index());
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start every chunk as a single-chunk run, overflow once, then release in order
    for (int i = 0; i < CHUNKS; i++) begin
      send_request(ccalloc_pkg::CMD_ALLOC,
                   ccalloc_pkg::SIZE_W'($urandom_range(CHUNK_BYTES_TB)), pick_index());
    end
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    for (int i = 0; i < CHUNKS; i++) begin
      send_request(ccalloc_pkg::CMD_FREE, pick_any_size(), i[ccalloc_pkg::IDX_W-1:0]);
    end

    // Rounding, oversized runs, bad frees and the search restart
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 1, 63);
    send_request(ccalloc_pkg::CMD_ALLOC, 64, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 65, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 8191, 63);
    send_request(ccalloc_pkg::CMD_ALLOC, 8128, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 4096, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 3);
    send_request(ccalloc_pkg::CMD_FREE, 8191, 3);
    send_request(ccalloc_pkg::CMD_FREE, 0, 4);
    send_request(ccalloc_pkg::CMD_FREE, 0, 63);
    send_request(ccalloc_pkg::CMD_FREE, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 128, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 2);
    send_request(ccalloc_pkg::CMD_FREE, 0, 1);
    send_request(ccalloc_pkg::CMD_FREE, 0, 3);
    send_request(ccalloc_pkg::CMD_ALLOC, 4096, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 42);
    send_request(ccalloc_pkg::CMD_FREE, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 4097, 0);

    // Shrink the pool under live runs, then run with an empty and a one-chunk pool
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 200, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 64, 0);
    set_pool_chunks(0);
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 8191, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 1);
    set_pool_chunks(1);
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 1, 0);
    send_request(ccalloc_pkg::CMD_ALLOC, 0, 0);
    send_request(ccalloc_pkg::CMD_FREE, 0, 5);
    send_request(ccalloc_pkg::CMD_FREE, 0, 0);

    // Oversized pool setting, light sender gaps and heavy response stalls
    set_pool_chunks(127);
    run_random(400, 120, 300);

    // Mid-size pool, heavy sender gaps and light response stalls
    set_pool_chunks(20);
    tx_idle_pct = 59;
    rx_idle_pct <= 21;
    run_random(400, 200, 100);

    // Full pool, no random gaps on either side, one long response hold
    set_pool_chunks(64);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_random(340, 150, 300);

    settle_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
